/* hdl/afr_pkg.sv */
// Shared types and constants for the aspect fit/fill rectangle placer.
package afr_pkg;

    localparam int DIV_BITS = 30;
    localparam int QUEUE_DEPTH = 4;

    // Placement class decided by the front end
    localparam logic [2:0] K_EQUAL  = 3'd0;
    localparam logic [2:0] K_DEST   = 3'd1;
    localparam logic [2:0] K_CENTER = 3'd2;
    localparam logic [2:0] K_ZERO   = 3'd3;
    localparam logic [2:0] K_SCALE  = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic               fit;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [14:0]        sw;
        logic [14:0]        sh;
        logic [14:0]        dw;
        logic [14:0]        dh;
    } job_t;

endpackage

/* hdl/afr_if.sv */
// Request and response channel interfaces of the rectangle placer.
interface afr_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [14:0]        src_w;
    logic [14:0]        src_h;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [14:0]        dst_w;
    logic [14:0]        dst_h;
    logic               mode_fit;
    logic               mode_fill;

    modport source (output valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h,
                     mode_fit, mode_fill, input ready);
    modport sink (input valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h,
                   mode_fit, mode_fill, output ready);
endinterface

interface afr_rsp_if;
    logic               valid;
    logic               ready;
    logic               updated;
    logic signed [30:0] out_x;
    logic signed [30:0] out_y;
    logic [29:0]        out_w;
    logic [29:0]        out_h;

    modport source (output valid, updated, out_x, out_y, out_w, out_h, input ready);
    modport sink (input valid, updated, out_x, out_y, out_w, out_h, output ready);
endinterface

/* hdl/afr_queue.sv */
// Small FIFO of classified jobs between front and back end.
module afr_queue
    import afr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t rd_job,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full   = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* hdl/afr_front.sv */
// Front end: takes request items and classifies them into jobs.
module afr_front
    import afr_pkg::*;
(
    afr_req_if.sink req,
    input  logic    q_full,
    output logic    push,
    output job_t    job
);

    logic same;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // classification
    always_comb
    begin
        same = (req.src_x == req.dst_x) && (req.src_y == req.dst_y) &&
               (req.src_w == req.dst_w) && (req.src_h == req.dst_h);
        job.fit = req.mode_fit;
        job.dx  = req.dst_x;
        job.dy  = req.dst_y;
        job.sw  = req.src_w;
        job.sh  = req.src_h;
        job.dw  = req.dst_w;
        job.dh  = req.dst_h;
        if (same)
            job.kind = K_EQUAL;
        else if (req.mode_fit && req.mode_fill)
            job.kind = K_DEST;
        else if (!req.mode_fit && !req.mode_fill)
            job.kind = K_CENTER;
        else if (req.src_w == '0 || req.src_h == '0)
            job.kind = K_ZERO;
        else
            job.kind = K_SCALE;
    end

endmodule

/* hdl/afr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module afr_div
    import afr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_BITS-1:0] num,
    input  logic [14:0]       den,
    output logic [DIV_BITS-1:0] quot
);

    logic [14:0]         rem_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] num_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] quot_reg [DIV_BITS];
    logic [14:0]         den_reg  [DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic [14:0]         rin;
        logic [DIV_BITS-1:0] nin;
        logic [DIV_BITS-1:0] qin;
        logic [14:0]         din;
        logic [15:0]         trial;
        logic                ge;

        if (k == 0)
        begin : g_first
            assign rin = '0;
            assign nin = num;
            assign qin = '0;
            assign din = den;
        end
        else
        begin : g_rest
            assign rin = rem_reg[k-1];
            assign nin = num_reg[k-1];
            assign qin = quot_reg[k-1];
            assign din = den_reg[k-1];
        end

        // shift in next numerator bit, subtract when it fits
        assign trial = {rin, nin[DIV_BITS-1]};
        assign ge    = (trial >= {1'b0, din});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? 15'(trial - {1'b0, din}) : trial[14:0];
                num_reg[k]  <= {nin[DIV_BITS-2:0], 1'b0};
                quot_reg[k] <= {qin[DIV_BITS-2:0], ge};
                den_reg[k]  <= din;
            end
        end
    end

    assign quot = quot_reg[DIV_BITS-1];

endmodule

/* hdl/afr_back.sv */
// Back end: multiply, divide and place, with registered response output.
module afr_back
    import afr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  job_t     q_job,
    output logic     pop,
    afr_rsp_if.source rsp
);

    localparam int NS = DIV_BITS + 1;

    job_t                job_pipe_reg [NS];
    logic [NS-1:0]       vld_reg;
    logic [DIV_BITS-1:0] n1_reg;
    logic [DIV_BITS-1:0] n2_reg;
    logic [DIV_BITS-1:0] q1;
    logic [DIV_BITS-1:0] q2;
    logic                adv;

    logic                out_valid_reg;
    logic                upd_reg;
    logic signed [30:0]  x_reg;
    logic signed [30:0]  y_reg;
    logic [29:0]         w_reg;
    logic [29:0]         h_reg;

    logic                upd_next;
    logic signed [30:0]  x_next;
    logic signed [30:0]  y_next;
    logic [29:0]         w_next;
    logic [29:0]         h_next;

    // whole pipeline moves while the output slot is free or being taken
    assign adv = !out_valid_reg || rsp.ready;
    assign pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NS-2:0], !q_empty};
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    // product stage and job side pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            job_pipe_reg[0] <= q_job;
            n1_reg <= DIV_BITS'(q_job.sh) * DIV_BITS'(q_job.dw);
            n2_reg <= DIV_BITS'(q_job.sw) * DIV_BITS'(q_job.dh);
            for (int k = 1; k < NS; k++)
                job_pipe_reg[k] <= job_pipe_reg[k-1];
        end
    end

    // candidate height and width
    afr_div u_div_h (.clk(clk), .en(adv), .num(n1_reg), .den(job_pipe_reg[0].sw), .quot(q1));
    afr_div u_div_w (.clk(clk), .en(adv), .num(n2_reg), .den(job_pipe_reg[0].sh), .quot(q2));

    // final placement
    always_comb
    begin
        job_t               j;
        logic signed [30:0] dx31;
        logic signed [30:0] dy31;
        logic signed [16:0] cdw;
        logic signed [16:0] cdh;
        logic               swap;
        logic [29:0]        pw;
        logic [29:0]        ph;
        logic signed [31:0] sdw;
        logic signed [31:0] sdh;
        logic signed [31:0] hw;
        logic signed [31:0] hh;

        j    = job_pipe_reg[NS-1];
        dx31 = 31'(j.dx);
        dy31 = 31'(j.dy);
        cdw  = $signed({2'b00, j.dw}) - $signed({2'b00, j.sw});
        cdh  = $signed({2'b00, j.dh}) - $signed({2'b00, j.sh});
        swap = j.fit ? (q1 > 30'(j.dh)) : (q1 < 30'(j.dh));
        pw   = swap ? q2 : 30'(j.dw);
        ph   = swap ? 30'(j.dh) : q1;
        sdw  = $signed({17'b0, j.dw}) - $signed({2'b00, pw});
        sdh  = $signed({17'b0, j.dh}) - $signed({2'b00, ph});
        hw   = (sdw + $signed({31'b0, sdw[31]})) >>> 1;
        hh   = (sdh + $signed({31'b0, sdh[31]})) >>> 1;

        upd_next = 1'b1;
        x_next   = dx31;
        y_next   = dy31;
        w_next   = 30'(j.dw);
        h_next   = 30'(j.dh);
        case (j.kind)
            K_EQUAL:
            begin
                upd_next = 1'b0;
            end
            K_DEST:
            begin
                upd_next = 1'b1;
            end
            K_CENTER:
            begin
                x_next = dx31 + 31'(cdw >>> 1);
                y_next = dy31 + 31'(cdh >>> 1);
                w_next = 30'(j.sw);
                h_next = 30'(j.sh);
            end
            K_ZERO:
            begin
                x_next = '0;
                y_next = '0;
                w_next = '0;
                h_next = '0;
            end
            K_SCALE:
            begin
                x_next = dx31 + hw[30:0];
                y_next = dy31 + hh[30:0];
                w_next = pw;
                h_next = ph;
            end
            default:
            begin
                upd_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            upd_reg <= upd_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            w_reg   <= w_next;
            h_reg   <= h_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.updated = upd_reg;
    assign rsp.out_x   = x_reg;
    assign rsp.out_y   = y_reg;
    assign rsp.out_w   = w_reg;
    assign rsp.out_h   = h_reg;

    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n) pop |=> vld_reg[0])
        else $error("popped job did not enter the pipeline");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[NS-1]))
        else $error("response without job in last stage");

endmodule

/* hdl/aspect_fit_fill_rect_core.sv */
// Aspect fit/fill rectangle placer: top level.
// Usage:
//   req carries one placement item: source and destination rectangles and
//   the fit and fill mode bits. It is taken when req.valid and req.ready are
//   both high at a rising clk edge.
//   rsp returns exactly one item per request, in order: updated flag and the
//   placed rectangle, taken when rsp.valid and rsp.ready are both high.
// Path: an accepted item passes from the queue into the product stage,
//   through 30 divider stages, then into the output register fed by the
//   combinational placement logic.
// Throughput: one item per cycle when nothing stalls; the two dividers each retire one
//   quotient bit per stage, so a new item enters every cycle while unstalled.
// Stall: rsp.valid high with rsp.ready low holds the back pipeline; the
//   four-entry job queue keeps taking items until full, then req.ready drops.
// Reset: rst_n (asynchronous, active low) empties the queue and all stages;
//   no item is in flight afterwards.
module aspect_fit_fill_rect_core
    import afr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    afr_req_if.sink   req,
    afr_rsp_if.source rsp
);

    job_t fr_job;
    job_t q_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    afr_front u_front (
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .job    (fr_job)
    );

    afr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (fr_job),
        .full   (q_full),
        .pop    (pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    afr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_job),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule
